// ===== hw/rtl/es2cal_pkg.sv =====
// Shared constants and helper functions for the epoch-seconds to calendar converter.
// Depends on nothing; the core uses it by scoped names.
`default_nettype none

package es2cal_pkg;

   // Pipeline depth of the core: one output register at the last stage.
   localparam int NUM_STAGES = 8;

   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [17:0] SECS_PER_DAY_R = 18'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0] SECS_PER_MIN  = 12'd60;
   localparam logic [11:0] BASE_YEAR     = 12'd1970;

   // Reciprocals for division by constants (multiply, then take the high bits).
   // Day split: (t >> 7) / 675, low by at most one, fixed by a remainder compare.
   localparam logic [25:0] DAY_RECIP  = 26'd50903316;
   // Exact for every second of a day: floor(s / 3600) = (s * HOUR_RECIP) >> 30.
   localparam logic [18:0] HOUR_RECIP = 19'd298262;
   // Exact below 3600: floor(r / 60) = (r * MIN_RECIP) >> 22.
   localparam logic [16:0] MIN_RECIP  = 17'd69906;
   // Exact below 2^16: floor(d / 365) = (d * YEAR_RECIP) >> 24.
   localparam logic [15:0] YEAR_RECIP = 16'd45965;

   // Year index (from 1970) whose low two bits mark a leap year, and the
   // century year (2100) that breaks the rule.
   localparam logic [1:0] LEAP_PHASE    = 2'd2;
   localparam logic [7:0] LEAP_SKIP_IDX = 8'd130;

   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   // Day count from the epoch to January 1st of year 1970 + idx.
   function automatic logic [15:0] year_start(input logic [7:0] idx);
      logic [15:0] base;
      logic [15:0] leaps;
      base  = 16'(idx) * 16'd365;
      leaps = 16'((9'(idx) + 9'd1) >> 2);
      if (idx > LEAP_SKIP_IDX) begin
         leaps = leaps - 16'd1;
      end
      return base + leaps;
   endfunction

   // Day of year at which month mon (0 is January) starts.
   function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
      logic [8:0] base;
      unique case (mon)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (mon > MONTH_FEB)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

   // Month (0 is January) that holds day of year doy; independent compares.
   function automatic logic [3:0] month_index(input logic [8:0] doy, input logic leap);
      logic [3:0] idx;
      idx = 4'd0;
      for (int m = 1; m <= int'(MONTH_DEC); m++) begin
         if (doy >= month_start(4'(m), leap)) begin
            idx = 4'(m);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/es2cal_if.sv =====
// Valid/ready channel interfaces for the request and the response of the converter.
// Depends on nothing.
`default_nettype none

interface es2cal_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2cal_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (output valid, output year, output month, output day,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day,
                   input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_calendar_core.sv =====
// Epoch seconds to Gregorian date and time of day, eight-stage pipeline.
// Throughput: one request per cycle; each stage moves when its successor has room.
// Reset (synchronous, active high) clears the stage valid bits only; no request in flight survives it.
// Depends on es2cal_pkg and es2cal_if.
`default_nettype none

module epoch_seconds_to_calendar_core (
   input  wire logic     clock,
   input  wire logic     reset,
   es2cal_req_if.sink    req_if,
   es2cal_rsp_if.source  rsp_if
);

   // ---------------------------------------------------------------------
   // Stage control: a stage loads when it is empty or its successor loads.
   // ---------------------------------------------------------------------
   logic [es2cal_pkg::NUM_STAGES:1] vld_ff;
   logic [es2cal_pkg::NUM_STAGES:1] vld_in;
   logic [es2cal_pkg::NUM_STAGES:1] stage_go;

   always_comb begin
      stage_go[es2cal_pkg::NUM_STAGES] = !vld_ff[es2cal_pkg::NUM_STAGES] || rsp_if.ready;
      for (int k = es2cal_pkg::NUM_STAGES - 1; k >= 1; k--) begin
         stage_go[k] = !vld_ff[k] || stage_go[k + 1];
      end
   end

   always_comb begin
      vld_in[1] = stage_go[1] ? req_if.valid : vld_ff[1];
      for (int k = 2; k <= es2cal_pkg::NUM_STAGES; k++) begin
         vld_in[k] = stage_go[k] ? vld_ff[k - 1] : vld_ff[k];
      end
   end

   assign req_if.ready = stage_go[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: estimate the day count as (t >> 7) / 675 by reciprocal.
   // The estimate is exact or one low.
   // ---------------------------------------------------------------------
   logic [50:0] day_prod;
   logic [31:0] t1_ff, t1_in;
   logic [15:0] q1_ff, q1_in;

   assign day_prod = {26'd0, req_if.epoch_seconds[31:7]} * {25'd0, es2cal_pkg::DAY_RECIP};
   assign t1_in    = req_if.epoch_seconds;
   assign q1_in    = day_prod[50:35];

   // ---------------------------------------------------------------------
   // Stage 2: multiply the estimate back to seconds.
   // ---------------------------------------------------------------------
   logic [31:0] t2_ff, t2_in;
   logic [15:0] q2_ff, q2_in;
   logic [31:0] qm2_ff, qm2_in;

   assign t2_in  = t1_ff;
   assign q2_in  = q1_ff;
   assign qm2_in = {16'd0, q1_ff} * es2cal_pkg::SECS_PER_DAY;

   // ---------------------------------------------------------------------
   // Stage 3: take the remainder and fix a low estimate with one compare.
   // ---------------------------------------------------------------------
   logic [31:0] rem_full;
   logic [17:0] rem_day;
   logic [16:0] sod3_ff, sod3_in;
   logic [15:0] days3_ff, days3_in;

   assign rem_full = t2_ff - qm2_ff;
   assign rem_day  = rem_full[17:0];

   always_comb begin
      if (rem_day >= es2cal_pkg::SECS_PER_DAY_R) begin
         sod3_in  = 17'(rem_day - es2cal_pkg::SECS_PER_DAY_R);
         days3_in = q2_ff + 16'd1;
      end else begin
         sod3_in  = rem_day[16:0];
         days3_in = q2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: hour of day and a year estimate, both by reciprocal.
   // The year estimate (days / 365) is the true year or one above.
   // ---------------------------------------------------------------------
   logic [35:0] hour_prod;
   logic [31:0] year_prod;
   logic [16:0] sod4_ff, sod4_in;
   logic [15:0] days4_ff, days4_in;
   logic [4:0]  hour4_ff, hour4_in;
   logic [7:0]  yest4_ff, yest4_in;

   assign hour_prod = {19'd0, sod3_ff} * {17'd0, es2cal_pkg::HOUR_RECIP};
   assign year_prod = {16'd0, days3_ff} * {16'd0, es2cal_pkg::YEAR_RECIP};
   assign sod4_in   = sod3_ff;
   assign days4_in  = days3_ff;
   assign hour4_in  = hour_prod[34:30];
   assign yest4_in  = year_prod[31:24];

   // ---------------------------------------------------------------------
   // Stage 5: hour back to seconds; start days of the estimated year and
   // the one before it.
   // ---------------------------------------------------------------------
   logic [16:0] sod5_ff, sod5_in;
   logic [15:0] days5_ff, days5_in;
   logic [4:0]  hour5_ff, hour5_in;
   logic [7:0]  yest5_ff, yest5_in;
   logic [16:0] hsec5_ff, hsec5_in;
   logic [15:0] ys_hi5_ff, ys_hi5_in;
   logic [15:0] ys_lo5_ff, ys_lo5_in;

   assign sod5_in   = sod4_ff;
   assign days5_in  = days4_ff;
   assign hour5_in  = hour4_ff;
   assign yest5_in  = yest4_ff;
   assign hsec5_in  = {12'd0, hour4_ff} * es2cal_pkg::SECS_PER_HOUR;
   assign ys_hi5_in = es2cal_pkg::year_start(yest4_ff);
   assign ys_lo5_in = (yest4_ff == 8'd0) ? 16'd0 : es2cal_pkg::year_start(yest4_ff - 8'd1);

   // ---------------------------------------------------------------------
   // Stage 6: settle the year, the day of year and the leap flag; take the
   // seconds within the hour.
   // ---------------------------------------------------------------------
   logic [4:0]  hour6_ff, hour6_in;
   logic [11:0] remh6_ff, remh6_in;
   logic [7:0]  yidx6_ff, yidx6_in;
   logic [8:0]  doy6_ff, doy6_in;
   logic        leap6_ff, leap6_in;

   assign hour6_in = hour5_ff;
   assign remh6_in = 12'(sod5_ff - hsec5_ff);

   always_comb begin
      if (days5_ff < ys_hi5_ff) begin
         yidx6_in = yest5_ff - 8'd1;
         doy6_in  = 9'(days5_ff - ys_lo5_ff);
      end else begin
         yidx6_in = yest5_ff;
         doy6_in  = 9'(days5_ff - ys_hi5_ff);
      end
   end

   assign leap6_in = (yidx6_in[1:0] == es2cal_pkg::LEAP_PHASE) &&
                     (yidx6_in != es2cal_pkg::LEAP_SKIP_IDX);

   // ---------------------------------------------------------------------
   // Stage 7: minute by reciprocal; month by parallel compares against the
   // month start days.
   // ---------------------------------------------------------------------
   logic [28:0] min_prod;
   logic [4:0]  hour7_ff, hour7_in;
   logic [11:0] remh7_ff, remh7_in;
   logic [5:0]  minute7_ff, minute7_in;
   logic [7:0]  yidx7_ff, yidx7_in;
   logic [8:0]  doy7_ff, doy7_in;
   logic        leap7_ff, leap7_in;
   logic [3:0]  mon7_ff, mon7_in;

   assign min_prod   = {17'd0, remh6_ff} * {12'd0, es2cal_pkg::MIN_RECIP};
   assign hour7_in   = hour6_ff;
   assign remh7_in   = remh6_ff;
   assign minute7_in = min_prod[27:22];
   assign yidx7_in   = yidx6_ff;
   assign doy7_in    = doy6_ff;
   assign leap7_in   = leap6_ff;
   assign mon7_in    = es2cal_pkg::month_index(doy6_ff, leap6_ff);

   // ---------------------------------------------------------------------
   // Stage 8 (output register): second, day of month, month and year.
   // ---------------------------------------------------------------------
   logic [11:0] msec;
   logic [8:0]  dom0;
   logic [11:0] year8_ff, year8_in;
   logic [3:0]  month8_ff, month8_in;
   logic [4:0]  day8_ff, day8_in;
   logic [4:0]  hour8_ff, hour8_in;
   logic [5:0]  minute8_ff, minute8_in;
   logic [5:0]  second8_ff, second8_in;

   assign msec       = {6'd0, minute7_ff} * es2cal_pkg::SECS_PER_MIN;
   assign dom0       = doy7_ff - es2cal_pkg::month_start(mon7_ff, leap7_ff);
   assign second8_in = 6'(remh7_ff - msec);
   assign day8_in    = 5'(dom0 + 9'd1);
   assign month8_in  = mon7_ff + 4'd1;
   assign year8_in   = es2cal_pkg::BASE_YEAR + {4'd0, yidx7_ff};
   assign hour8_in   = hour7_ff;
   assign minute8_in = minute7_ff;

   // ---------------------------------------------------------------------
   // Payload registers: load on the stage's advance, hold otherwise.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (stage_go[1]) begin
         t1_ff <= t1_in;
         q1_ff <= q1_in;
      end
      if (stage_go[2]) begin
         t2_ff  <= t2_in;
         q2_ff  <= q2_in;
         qm2_ff <= qm2_in;
      end
      if (stage_go[3]) begin
         sod3_ff  <= sod3_in;
         days3_ff <= days3_in;
      end
      if (stage_go[4]) begin
         sod4_ff  <= sod4_in;
         days4_ff <= days4_in;
         hour4_ff <= hour4_in;
         yest4_ff <= yest4_in;
      end
      if (stage_go[5]) begin
         sod5_ff   <= sod5_in;
         days5_ff  <= days5_in;
         hour5_ff  <= hour5_in;
         yest5_ff  <= yest5_in;
         hsec5_ff  <= hsec5_in;
         ys_hi5_ff <= ys_hi5_in;
         ys_lo5_ff <= ys_lo5_in;
      end
      if (stage_go[6]) begin
         hour6_ff <= hour6_in;
         remh6_ff <= remh6_in;
         yidx6_ff <= yidx6_in;
         doy6_ff  <= doy6_in;
         leap6_ff <= leap6_in;
      end
      if (stage_go[7]) begin
         hour7_ff   <= hour7_in;
         remh7_ff   <= remh7_in;
         minute7_ff <= minute7_in;
         yidx7_ff   <= yidx7_in;
         doy7_ff    <= doy7_in;
         leap7_ff   <= leap7_in;
         mon7_ff    <= mon7_in;
      end
      if (stage_go[8]) begin
         year8_ff   <= year8_in;
         month8_ff  <= month8_in;
         day8_ff    <= day8_in;
         hour8_ff   <= hour8_in;
         minute8_ff <= minute8_in;
         second8_ff <= second8_in;
      end
   end

   // Drive the response from the last stage.
   assign rsp_if.valid  = vld_ff[es2cal_pkg::NUM_STAGES];
   assign rsp_if.year   = year8_ff;
   assign rsp_if.month  = month8_ff;
   assign rsp_if.day    = day8_ff;
   assign rsp_if.hour   = hour8_ff;
   assign rsp_if.minute = minute8_ff;
   assign rsp_if.second = second8_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/es2cal_chk.sv =====
// Port-level checker for the converter core, attached by bind.
// Depends on epoch_seconds_to_calendar_core and its channel interfaces.
`default_nettype none

module es2cal_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [11:0] rsp_year,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day,
   input wire logic [4:0]  rsp_hour,
   input wire logic [5:0]  rsp_minute,
   input wire logic [5:0]  rsp_second
);

   // Drop every response in flight on reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_year, rsp_month, rsp_day,
                                                      rsp_hour, rsp_minute, rsp_second}))
      else $error("stalled response changed or dropped");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1 &&
                    rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59 &&
                    rsp_year >= 12'd1970 && rsp_year <= 12'd2106)
      else $error("response field out of range");

   a_short_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_month == 4'd4 || rsp_month == 4'd6 || rsp_month == 4'd9 ||
                    rsp_month == 4'd11) |-> rsp_day <= 5'd30)
      else $error("day 31 in a 30-day month");

   a_february: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_month == 4'd2 |-> rsp_day <= 5'd28 ||
                                        (rsp_day == 5'd29 && rsp_year[1:0] == 2'd0 &&
                                         rsp_year != 12'd2100))
      else $error("February day beyond the month");

endmodule

bind epoch_seconds_to_calendar_core es2cal_chk u_es2cal_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_year   (rsp_if.year),
   .rsp_month  (rsp_if.month),
   .rsp_day    (rsp_if.day),
   .rsp_hour   (rsp_if.hour),
   .rsp_minute (rsp_if.minute),
   .rsp_second (rsp_if.second)
);

`default_nettype wire

// ===== tb/sv/epoch_seconds_to_calendar_core_tb.sv =====
// Self-checking testbench for epoch_seconds_to_calendar_core: epoch seconds in, calendar out.
// Depends on hw/rtl/es2cal_if.sv (es2cal_req_if, es2cal_rsp_if) and the core itself.
// Runs directed rows, then random requests under four idle mixes and a long output hold-off.
`default_nettype none

module epoch_seconds_to_calendar_core_tb;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 3;
   // Wait after the last expected response so that stray responses
   // have time to show up.
   localparam int DRAIN_CYCLES   = 40;
   localparam int TIMEOUT_CYCLES = 400000;

   localparam int NUM_PHASES       = 4;
   localparam int ITEMS_PER_PHASE  = 190;
   localparam int PRESSURE_ITEMS   = 40;
   localparam int HOLD_OFF_CYCLES  = 150;

   // Sender idle and receiver stall odds, in percent, per phase:
   // none, sender only, receiver only, both.
   localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 77, 0, 21};
   localparam int RSP_STALL_PCT [NUM_PHASES] = '{0, 0, 77, 21};

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned EPOCH_YEAR    = 1970;
   localparam int unsigned LAST_DAY      = 49710;   // last day whose midnight fits in 32 bits
   localparam int unsigned FEBRUARY      = 1;       // month index, January is 0
   localparam int unsigned DECEMBER      = 11;
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   // One accepted request and the calendar it must turn into.
   typedef struct packed {
      logic [31:0]  secs;
      calendar_type cal;
   } pending_type;

   // Directed row: typed = 1 means the calendar below is the answer;
   // otherwise the predictor works it out.
   typedef struct packed {
      logic [31:0]  secs;
      logic         typed;
      calendar_type cal;
   } stim_row_type;

   localparam int NUM_DIRECTED = 24;
   localparam calendar_type PREDICT = '0;

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      // epoch itself and the very last second that fits
      '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
      '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}},
      // time-of-day extremes on the first day
      '{32'd59,         1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd59}},
      '{32'd3599,       1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd59, 6'd59}},
      '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
      '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0}},
      '{32'd2678400,    1'b1, '{12'd1970, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0}},
      // first year rollover
      '{32'd31535999,   1'b1, '{12'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
      '{32'd31536000,   1'b1, '{12'd1971, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
      // first leap year: Feb 28, Feb 29, Mar 1, Dec 31, next Jan 1
      '{32'd68169599,   1'b0, PREDICT},
      '{32'd68169600,   1'b0, PREDICT},
      '{32'd68256000,   1'b0, PREDICT},
      '{32'd94694399,   1'b0, PREDICT},
      '{32'd94694400,   1'b0, PREDICT},
      // century year divisible by 400 is a leap year
      '{32'd946684799,  1'b0, PREDICT},
      '{32'd946684800,  1'b1, '{12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
      '{32'd951782400,  1'b0, PREDICT},
      '{32'd951868800,  1'b0, PREDICT},
      // signed 32-bit rollover point
      '{32'd2147483647, 1'b1, '{12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7}},
      '{32'd2147483648, 1'b0, PREDICT},
      // century year not divisible by 400 has no Feb 29
      '{32'd4102444800, 1'b0, PREDICT},
      '{32'd4107542399, 1'b0, PREDICT},
      '{32'd4107542400, 1'b0, PREDICT},
      // alternating bit patterns
      '{32'hAAAA_AAAA,  1'b0, PREDICT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   es2cal_req_if req_ch ();
   es2cal_rsp_if rsp_ch ();

   pending_type calendar_due_q [$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;
   int          rsp_hold_left  = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   epoch_seconds_to_calendar_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   // Split seconds into day count and time of day, step off whole years
   // from 1970, then whole months; month and day count from 1.
   function automatic calendar_type to_calendar(input logic [31:0] secs);
      int unsigned  day_num;
      int unsigned  tod;
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  span;
      calendar_type cal;
      tod     = secs % SECS_PER_DAY;
      day_num = secs / SECS_PER_DAY;
      yr      = EPOCH_YEAR;
      span    = is_leap_year(yr) ? 366 : 365;
      while (day_num >= span) begin
         day_num -= span;
         yr++;
         span = is_leap_year(yr) ? 366 : 365;
      end
      mo   = 0;
      span = MONTH_DAYS[0];
      while ((mo < DECEMBER) && (day_num >= span)) begin
         day_num -= span;
         mo++;
         span = MONTH_DAYS[mo] + (((mo == FEBRUARY) && is_leap_year(yr)) ? 1 : 0);
      end
      cal.year   = 12'(yr);
      cal.month  = 4'(mo + 1);
      cal.day    = 5'(day_num + 1);
      cal.hour   = 5'(tod / SECS_PER_HOUR);
      cal.minute = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
      cal.second = 6'(tod % SECS_PER_MIN);
      return cal;
   endfunction

   // Offer one request, idling first at the current odds; queue the
   // expected calendar at the edge where the request is taken.
   task automatic send_request(input logic [31:0] secs, input calendar_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.epoch_seconds <= secs;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      calendar_due_q.push_back('{secs: secs, cal: want});
   endtask

   task automatic compare_field(input string field, input logic [31:0] secs,
                                input logic [11:0] want, input logic [11:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch for epoch %0d: expected %0d, actual %0d",
                  $time, field, secs, want, got);
      end
   endtask

   // Response side: check every accepted response against the oldest
   // pending calendar, then pick ready for the next edge.
   initial begin : rsp_side
      pending_type  due;
      calendar_type got;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.year, rsp_ch.month, rsp_ch.day,
                   rsp_ch.hour, rsp_ch.minute, rsp_ch.second};
            if (calendar_due_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with no request pending: expected none, actual %p",
                        $time, got);
            end else begin
               due = calendar_due_q.pop_front();
               compare_field("year",   due.secs, 12'(due.cal.year),   12'(got.year));
               compare_field("month",  due.secs, 12'(due.cal.month),  12'(got.month));
               compare_field("day",    due.secs, 12'(due.cal.day),    12'(got.day));
               compare_field("hour",   due.secs, 12'(due.cal.hour),   12'(got.hour));
               compare_field("minute", due.secs, 12'(due.cal.minute), 12'(got.minute));
               compare_field("second", due.secs, 12'(due.cal.second), 12'(got.second));
            end
         end
         // Hold ready low through a requested hold-off, else stall at the current odds.
         if (rsp_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Request side: reset, directed rows, random phases, hold-off, drain, verdict.
   initial begin : req_side
      logic [31:0] secs;
      int unsigned pick;
      req_ch.valid         = 1'b0;
      req_ch.epoch_seconds = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table back to back.
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         send_request(directed_rows[r].secs,
                      directed_rows[r].typed ? directed_rows[r].cal
                                             : to_calendar(directed_rows[r].secs));
      end

      // Random requests: half anywhere in range, some straddling a midnight,
      // some near the top of the 32-bit range.
      for (int ph = 0; ph <= NUM_PHASES; ph++) begin
         if (ph < NUM_PHASES) begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            rsp_stall_pct = RSP_STALL_PCT[ph];
         end else begin
            // Hold off the output for a long stretch while requests keep
            // coming, so the pipeline fills and back-pressures its input.
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            rsp_hold_left = HOLD_OFF_CYCLES;
         end
         for (int n = 0; n < ((ph < NUM_PHASES) ? ITEMS_PER_PHASE : PRESSURE_ITEMS); n++) begin
            pick = $urandom_range(9);
            if (pick < 5) begin
               secs = $urandom();
            end else if (pick < 8) begin
               secs = 32'($urandom_range(LAST_DAY, 1) * SECS_PER_DAY - $urandom_range(1, 0));
            end else begin
               secs = 32'hFFFF_FFFF - 32'($urandom_range(32'h0040_0000, 0));
            end
            send_request(secs, to_calendar(secs));
         end
      end
      req_ch.valid <= 1'b0;

      // Drain: let every pending response arrive, then watch for strays.
      rsp_stall_pct = 0;
      while (calendar_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** epoch_seconds_to_calendar_core: PASSED **");
      end else begin
         $display("** epoch_seconds_to_calendar_core: FAILED **");
      end
      $finish;
   end

   // Watchdog: end the run if the handshakes never complete.
   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("%0t: timeout with %0d responses pending", $time, calendar_due_q.size());
      $display("** epoch_seconds_to_calendar_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
